[rtl/cilp_pkg.sv]
// Shared types, codes and helpers for the C integer literal parser.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package cilp_pkg;

    localparam int ValueBits = 64;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_SUFFIX = 3'd4;

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_HEX = 2'd1;
    localparam logic [1:0] RX_BIN = 2'd2;
    localparam logic [1:0] RX_OCT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic [1:0] REG_INT_BITS    = 2'd0;
    localparam logic [1:0] REG_LONG_BITS   = 2'd1;
    localparam logic [1:0] REG_BITINT_BITS = 2'd2;

    localparam logic [2:0] CL_INT    = 3'd0;
    localparam logic [2:0] CL_UINT   = 3'd1;
    localparam logic [2:0] CL_LONG   = 3'd2;
    localparam logic [2:0] CL_ULONG  = 3'd3;
    localparam logic [2:0] CL_LLONG  = 3'd4;
    localparam logic [2:0] CL_ULLONG = 3'd5;
    localparam logic [2:0] CL_BITINT = 3'd6;
    localparam logic [2:0] CL_UBITINT = 3'd7;

    // Token state carried from one character to the next.
    typedef struct packed {
        logic [2:0]           phase;
        logic [1:0]           radix;
        logic [ValueBits-1:0] accum;
        logic                 sep_seen;
        logic [23:0]          suffix_chars;
        logic [2:0]           suffix_count;
        logic [1:0]           error_code;
    } tok_t;

    // Token state handed to the result stage on the final character.
    typedef struct packed {
        logic [2:0]           phase;
        logic [1:0]           radix;
        logic [ValueBits-1:0] accum;
        logic [23:0]          suffix_chars;
        logic [2:0]           suffix_count;
        logic [1:0]           error_code;
    } fin_t;

    // Matches a suffix; returns {found, class}.
    function automatic logic [3:0] suffix_lookup(input logic [23:0] s, input logic [2:0] n);
        logic [7:0] a, b, c;
        logic [3:0] r;
        a = s[7:0];
        b = s[15:8];
        c = s[23:16];
        r = 4'b0;
        if (n == 3'd1) begin
            if (a == "L" || a == "l") r = {1'b1, CL_LONG};
            if (a == "U" || a == "u") r = {1'b1, CL_UINT};
        end else if (n == 3'd2) begin
            if ((a == "L" && b == "L") || (a == "l" && b == "l")) r = {1'b1, CL_LLONG};
            if (((a == "L" || a == "l") && (b == "U" || b == "u"))
                || ((a == "U" || a == "u") && (b == "L" || b == "l")))
                r = {1'b1, CL_ULONG};
            if ((a == "W" && b == "B") || (a == "w" && b == "b")) r = {1'b1, CL_BITINT};
        end else if (n == 3'd3) begin
            if (((a == "L" && b == "L") || (a == "l" && b == "l")) && (c == "U" || c == "u"))
                r = {1'b1, CL_ULLONG};
            if ((a == "U" || a == "u") && ((b == "L" && c == "L") || (b == "l" && c == "l")))
                r = {1'b1, CL_ULLONG};
            if ((a == "U" || a == "u") && ((b == "W" && c == "B") || (b == "w" && c == "b")))
                r = {1'b1, CL_UBITINT};
            if (((a == "W" && b == "B") || (a == "w" && b == "b")) && (c == "U" || c == "u"))
                r = {1'b1, CL_UBITINT};
        end
        return r;
    endfunction

    // Saturates a configured width to lo..64.
    function automatic logic [6:0] clamp_w(input logic [6:0] w, input logic [6:0] lo);
        logic [6:0] r;
        r = w;
        if (w < lo) r = lo;
        if (w > 7'd64) r = 7'd64;
        return r;
    endfunction

endpackage

[rtl/cilp_scan.sv]
// Per-character scanner: radix detection, digit accumulation, separators, suffix.
// Depends on cilp_pkg.
`timescale 1ns / 1ps

module cilp_scan
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [7:0]                 ch,
    input  logic                       last,
    output cilp_pkg::fin_t             fin
);

    cilp_pkg::tok_t tok_reg, tok_next, cur;
    logic [7:0]     lc;
    logic [4:0]     dig;
    logic [4:0]     base;
    logic [67:0]    prod;
    logic [68:0]    sum;

    // Suffix character store with overflow marker.
    function automatic cilp_pkg::tok_t add_sfx(input cilp_pkg::tok_t t, input logic [7:0] c);
        cilp_pkg::tok_t r;
        r = t;
        if (t.suffix_count < 3'd3) begin
            r.suffix_chars[8*t.suffix_count[1:0] +: 8] = c;
            r.suffix_count = t.suffix_count + 3'd1;
        end else begin
            r.suffix_count = 3'd4;
        end
        return r;
    endfunction

    // Digit value of the character, 16 when not a hex digit.
    always_comb
    begin
        lc = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
        if (lc >= "0" && lc <= "9") dig = {1'b0, lc[3:0]};
        else if (lc >= "a" && lc <= "f") dig = 5'(lc - "a" + 8'd10);
        else dig = 5'd16;
    end

    // Radix and phase after the leading characters, then one digit step.
    always_comb
    begin
        cur = tok_reg;
        tok_next = tok_reg;
        base = 5'd10;
        prod = '0;
        sum = '0;
        if (tok_reg.error_code == cilp_pkg::ST_OK) begin
            unique case (tok_reg.phase)
                cilp_pkg::PH_START:
                begin
                    if (ch == "0") begin
                        cur.phase = cilp_pkg::PH_ZERO;
                        cur.radix = cilp_pkg::RX_OCT;
                    end else if (ch >= "1" && ch <= "9") begin
                        cur.phase = cilp_pkg::PH_DIGITS;
                    end else begin
                        cur.error_code = cilp_pkg::ST_INVALID;
                    end
                end
                cilp_pkg::PH_ZERO:
                begin
                    if (lc == "x") begin
                        cur.radix = cilp_pkg::RX_HEX;
                        cur.phase = cilp_pkg::PH_PREFIX;
                    end else if (lc == "b") begin
                        cur.radix = cilp_pkg::RX_BIN;
                        cur.phase = cilp_pkg::PH_PREFIX;
                    end else begin
                        cur.phase = cilp_pkg::PH_DIGITS;
                    end
                end
                cilp_pkg::PH_PREFIX, cilp_pkg::PH_DIGITS: cur.phase = cilp_pkg::PH_DIGITS;
                default: ;
            endcase
            tok_next = cur;
            // A digit step happens when the phase just became or stays digits.
            if (cur.phase == cilp_pkg::PH_DIGITS) begin
                unique case (cur.radix)
                    cilp_pkg::RX_HEX: base = 5'd16;
                    cilp_pkg::RX_BIN: base = 5'd2;
                    cilp_pkg::RX_OCT: base = 5'd8;
                    default:          base = 5'd10;
                endcase
                prod = cur.accum * 4'(base - 5'd1) + {4'b0, cur.accum};
                sum = {1'b0, prod} + {64'b0, dig};
                if (dig < base) begin
                    if (prod[67:64] != 4'b0 || sum[68:64] != 5'b0) begin
                        tok_next.error_code = cilp_pkg::ST_RANGE;
                    end else begin
                        tok_next.accum = sum[63:0];
                        tok_next.sep_seen = 1'b0;
                    end
                end else if (ch == 8'h27) begin
                    if (cur.sep_seen) tok_next.error_code = cilp_pkg::ST_INVALID;
                    else tok_next.sep_seen = 1'b1;
                end else begin
                    tok_next = add_sfx(cur, ch);
                    tok_next.phase = cilp_pkg::PH_SUFFIX;
                end
            end else if (cur.phase == cilp_pkg::PH_SUFFIX) begin
                tok_next = add_sfx(cur, ch);
            end
        end
    end

    assign fin = '{phase: tok_next.phase, radix: tok_next.radix, accum: tok_next.accum,
                   suffix_chars: tok_next.suffix_chars,
                   suffix_count: tok_next.suffix_count,
                   error_code: tok_next.error_code};

    // Token state; cleared after the final character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_reg <= '0;
        end else if (take) begin
            if (last) tok_reg <= '0;
            else      tok_reg <= tok_next;
        end
    end

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !last && tok_reg.error_code != cilp_pkg::ST_OK)
        |=> (tok_reg.error_code == $past(tok_reg.error_code)))
        else $error("error code changed mid-token");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last) |=> (tok_reg == '0))
        else $error("token state not cleared");
    a_sfx_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_reg.suffix_count != 3'd0) |-> (tok_reg.phase == cilp_pkg::PH_SUFFIX))
        else $error("suffix count outside suffix phase");

endmodule

[rtl/cilp_finish.sv]
// Result logic: suffix match, type promotion and _BitInt width.
// Depends on cilp_pkg.
`timescale 1ns / 1ps

module cilp_finish
(
    input  cilp_pkg::fin_t fin,
    input  logic [6:0]     int_bits,
    input  logic [6:0]     long_bits,
    input  logic [6:0]     bitint_max_bits,
    output logic [1:0]     status,
    output logic [2:0]     type_class,
    output logic [6:0]     bitint_bits
);

    logic [1:0]  err;
    logic [3:0]  sfx;
    logic [2:0]  cls;
    logic [6:0]  iw, lw, lim, w;
    logic [5:0]  fits;
    logic [63:0] n;
    logic        dec_step;

    // Top set bit position of the value, at least one bit.
    always_comb
    begin
        w = 7'd1;
        for (int i = 0; i < 64; i++) begin
            if (n[i]) w = 7'(i + 1);
        end
    end

    always_comb
    begin
        n = fin.accum;
        iw = cilp_pkg::clamp_w(int_bits, 7'd16);
        lw = cilp_pkg::clamp_w(long_bits, 7'd16);
        lim = cilp_pkg::clamp_w(bitint_max_bits, 7'd2);
        // Value fits class k when it is below 2^(width - signed).
        fits[0] = (w <= iw - 7'd1);
        fits[1] = (w <= iw);
        fits[2] = (w <= lw - 7'd1);
        fits[3] = (w <= lw);
        fits[4] = !n[63];
        fits[5] = 1'b1;
        sfx = cilp_pkg::suffix_lookup(fin.suffix_chars, fin.suffix_count);
        err = fin.error_code;
        cls = cilp_pkg::CL_INT;
        bitint_bits = 7'd0;
        dec_step = 1'b0;
        if (err == cilp_pkg::ST_OK && (fin.phase == cilp_pkg::PH_PREFIX
                                       || fin.phase == cilp_pkg::PH_START))
            err = cilp_pkg::ST_INVALID;
        if (err == cilp_pkg::ST_OK && fin.phase == cilp_pkg::PH_SUFFIX) begin
            if (sfx[3]) cls = sfx[2:0];
            else err = cilp_pkg::ST_INVALID;
        end
        if (err == cilp_pkg::ST_OK) begin
            if (cls == cilp_pkg::CL_BITINT) begin
                if (w >= lim) err = cilp_pkg::ST_RANGE;
                else bitint_bits = w + 7'd1;
            end else if (cls == cilp_pkg::CL_UBITINT) begin
                if (w > lim) err = cilp_pkg::ST_RANGE;
                else bitint_bits = w;
            end else begin
                // Decimal signed classes skip the unsigned ones.
                dec_step = !cls[0] && fin.radix == cilp_pkg::RX_DEC;
                case (cls)
                    cilp_pkg::CL_INT:
                        if (fits[0]) cls = cilp_pkg::CL_INT;
                        else if (!dec_step && fits[1]) cls = cilp_pkg::CL_UINT;
                        else if (fits[2]) cls = cilp_pkg::CL_LONG;
                        else if (!dec_step && fits[3]) cls = cilp_pkg::CL_ULONG;
                        else if (fits[4]) cls = cilp_pkg::CL_LLONG;
                        else if (!dec_step) cls = cilp_pkg::CL_ULLONG;
                        else err = cilp_pkg::ST_RANGE;
                    cilp_pkg::CL_UINT:
                        if (fits[1]) cls = cilp_pkg::CL_UINT;
                        else if (fits[3]) cls = cilp_pkg::CL_ULONG;
                        else cls = cilp_pkg::CL_ULLONG;
                    cilp_pkg::CL_LONG:
                        if (fits[2]) cls = cilp_pkg::CL_LONG;
                        else if (!dec_step && fits[3]) cls = cilp_pkg::CL_ULONG;
                        else if (fits[4]) cls = cilp_pkg::CL_LLONG;
                        else if (!dec_step) cls = cilp_pkg::CL_ULLONG;
                        else err = cilp_pkg::ST_RANGE;
                    cilp_pkg::CL_ULONG:
                        if (fits[3]) cls = cilp_pkg::CL_ULONG;
                        else cls = cilp_pkg::CL_ULLONG;
                    cilp_pkg::CL_LLONG:
                        if (fits[4]) cls = cilp_pkg::CL_LLONG;
                        else if (!dec_step) cls = cilp_pkg::CL_ULLONG;
                        else err = cilp_pkg::ST_RANGE;
                    default: cls = cilp_pkg::CL_ULLONG;
                endcase
            end
        end
        status = err;
        type_class = (err == cilp_pkg::ST_OK) ? cls : 3'd0;
        if (err != cilp_pkg::ST_OK) bitint_bits = 7'd0;
    end

endmodule

[rtl/c_integer_literal_parser.sv]
// Top level of the C integer literal parser: config registers, scanner, output stage.
// Depends on cilp_pkg, cilp_scan and cilp_finish.
`timescale 1ns / 1ps
//
// Usage:
// One character enters per beat on s_axis (tdata = ch, tlast marks the final
// character of the literal). One result beat per literal is presented on m_axis
// from the cycle after its final character is accepted. tdata carries, from the
// lowest bit: status[1:0], type_class[4:2], bitint_bits[11:5], value[75:12].
// The block takes one character every cycle when not stalled; the token state
// register in the scanner is the only loop, closed by a single digit step. The
// output register frees itself in the cycle the receiver takes the beat, so a
// stalled receiver holds input only while a result is still waiting and a new
// final character arrives. Configuration writes (cfg_index 0 int_bits, 1
// long_bits, 2 bitint_max_bits) are taken at once; the user must write them
// only while idle, which the block does not enforce. Reset clears the token
// state and returns the widths to 32, 64 and 64. Non-final characters never stall.

module c_integer_literal_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status, type_class, bitint_bits, value, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [6:0]     int_bits_reg, long_bits_reg, bitint_bits_reg;
    logic           take;
    cilp_pkg::fin_t fin;
    logic [1:0]     status;
    logic [2:0]     type_class;
    logic [6:0]     bitint_bits;
    logic           out_valid_reg;
    logic [75:0]    out_data_reg;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready || !s_axis_tlast;
    assign take = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            int_bits_reg    <= 7'd32;
            long_bits_reg   <= 7'd64;
            bitint_bits_reg <= 7'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cilp_pkg::REG_INT_BITS:    int_bits_reg <= cfg_data;
                cilp_pkg::REG_LONG_BITS:   long_bits_reg <= cfg_data;
                cilp_pkg::REG_BITINT_BITS: bitint_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cilp_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .ch    (s_axis_tdata),
        .last  (s_axis_tlast),
        .fin   (fin)
    );

    cilp_finish u_finish
    (
        .fin             (fin),
        .int_bits        (int_bits_reg),
        .long_bits       (long_bits_reg),
        .bitint_max_bits (bitint_bits_reg),
        .status          (status),
        .type_class      (type_class),
        .bitint_bits     (bitint_bits)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (take && s_axis_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_axis_tlast) begin
            out_data_reg <= {(status == cilp_pkg::ST_OK) ? fin.accum : 64'd0,
                             bitint_bits, type_class, status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != cilp_pkg::ST_OK) |-> (m_axis_tdata[75:2] == '0))
        else $error("error result carries data");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_axis_tlast) |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwritten");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the C integer literal parser: streams literal
// characters, predicts each result in SystemVerilog and compares every result beat.
// Depends on cilp_pkg and the c_integer_literal_parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import cilp_pkg::*;

    // Laid out to match the result beat, status in the lowest bits.
    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  bitint_bits;
        logic [2:0]  type_class;
        logic [1:0]  status;
    } lit_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    c_integer_literal_parser dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: configured widths and the token being lexed.
    logic [6:0]  int_w;
    logic [6:0]  long_w;
    logic [6:0]  bitint_w;
    logic [2:0]  lex_phase;
    logic [1:0]  lex_radix;
    logic [63:0] lex_accum;
    logic        lex_sep;
    logic [23:0] lex_sfx;
    logic [2:0]  lex_sfx_n;
    logic [1:0]  lex_err;

    lit_result_t expected_results[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    // Clock and run limit.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [6:0] sat_width(input logic [6:0] w, input logic [6:0] lo);
        if (w < lo) return lo;
        if (w > 7'd64) return 7'd64;
        return w;
    endfunction

    function automatic logic [63:0] type_limit(input logic [2:0] cls);
        logic [6:0] w;
        if (cls < CL_LONG) w = sat_width(int_w, 7'd16);
        else if (cls < CL_LLONG) w = sat_width(long_w, 7'd16);
        else w = 7'd64;
        if (cls[0] == 1'b0) return ~64'd0 >> (65 - w);
        return ~64'd0 >> (64 - w);
    endfunction

    function automatic void flag_error(input logic [1:0] code);
        if (lex_err == ST_OK) lex_err = code;
    endfunction

    function automatic void push_suffix(input logic [7:0] c);
        if (lex_sfx_n < 3'd3) begin
            lex_sfx[8*lex_sfx_n +: 8] = c;
            lex_sfx_n = lex_sfx_n + 3'd1;
        end else begin
            lex_sfx_n = 3'd4;
        end
    endfunction

    function automatic void lex_digit(input logic [7:0] c);
        logic [7:0]  lc;
        logic [63:0] base;
        logic [63:0] d;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        d = 16;
        case (lex_radix)
            RX_HEX:  base = 16;
            RX_BIN:  base = 2;
            RX_OCT:  base = 8;
            default: base = 10;
        endcase
        if (lc >= "0" && lc <= "9") d = lc - "0";
        else if (lc >= "a" && lc <= "f") d = lc - "a" + 10;
        if (d < base) begin
            if (lex_accum > ~64'd0 / base) begin
                flag_error(ST_RANGE);
                return;
            end
            lex_accum = lex_accum * base;
            if (lex_accum > ~64'd0 - d) begin
                flag_error(ST_RANGE);
                return;
            end
            lex_accum = lex_accum + d;
            lex_sep = 1'b0;
        end else if (c == "'") begin
            if (lex_sep) flag_error(ST_INVALID);
            else lex_sep = 1'b1;
        end else begin
            lex_phase = PH_SUFFIX;
            push_suffix(c);
        end
    endfunction

    // Suffix table as a search: returns class, or 8 when not listed.
    function automatic int suffix_class(input logic [23:0] s, input logic [2:0] n);
        string t;
        t = "";
        for (int k = 0; k < n && k < 3; k++) t = {t, string'(s[8*k +: 8])};
        if (n == 1) begin
            if (t == "L" || t == "l") return CL_LONG;
            if (t == "U" || t == "u") return CL_UINT;
        end
        if (n == 2) begin
            if (t == "LL" || t == "ll") return CL_LLONG;
            if (t == "WB" || t == "wb") return CL_BITINT;
            if (t == "LU" || t == "Lu" || t == "UL" || t == "Ul" || t == "lU" || t == "lu"
                || t == "uL" || t == "ul") return CL_ULONG;
        end
        if (n == 3) begin
            if (t == "LLU" || t == "LLu" || t == "ULL" || t == "Ull" || t == "llU"
                || t == "llu" || t == "uLL" || t == "ull") return CL_ULLONG;
            if (t == "UWB" || t == "Uwb" || t == "WBU" || t == "WBu" || t == "uWB"
                || t == "uwb" || t == "wbU" || t == "wbu") return CL_UBITINT;
        end
        return 8;
    endfunction

    function automatic void clear_lexer();
        lex_phase = PH_START;
        lex_radix = RX_DEC;
        lex_accum = '0;
        lex_sep = 1'b0;
        lex_sfx = '0;
        lex_sfx_n = '0;
        lex_err = ST_OK;
    endfunction

    // Advances the predictor by one character; queues a result on the last one.
    function automatic void lex_char(input logic [7:0] c, input logic is_last);
        logic [7:0]  lc;
        lit_result_t r;
        int          cls;
        int          w;
        int          lim;
        int          stp;
        logic [63:0] t;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (lex_err == ST_OK) begin
            case (lex_phase)
                PH_START:
                    if (c == "0") begin
                        lex_phase = PH_ZERO;
                        lex_radix = RX_OCT;
                    end else if (c >= "1" && c <= "9") begin
                        lex_radix = RX_DEC;
                        lex_phase = PH_DIGITS;
                        lex_digit(c);
                    end else flag_error(ST_INVALID);
                PH_ZERO:
                    if (lc == "x") begin
                        lex_radix = RX_HEX;
                        lex_phase = PH_PREFIX;
                    end else if (lc == "b") begin
                        lex_radix = RX_BIN;
                        lex_phase = PH_PREFIX;
                    end else begin
                        lex_phase = PH_DIGITS;
                        lex_digit(c);
                    end
                PH_PREFIX, PH_DIGITS:
                begin
                    lex_phase = PH_DIGITS;
                    lex_digit(c);
                end
                default: push_suffix(c);
            endcase
        end
        if (!is_last) return;
        cls = 0;
        w = 0;
        if (lex_err == ST_OK && (lex_phase == PH_PREFIX || lex_phase == PH_START))
            flag_error(ST_INVALID);
        if (lex_err == ST_OK && lex_phase == PH_SUFFIX) begin
            cls = suffix_class(lex_sfx, lex_sfx_n);
            if (cls == 8) flag_error(ST_INVALID);
        end
        if (lex_err == ST_OK) begin
            if (cls >= 6) begin
                lim = sat_width(bitint_w, 7'd2);
                t = lex_accum;
                while (t != 0) begin
                    w++;
                    t = t >> 1;
                end
                if (w == 0) w = 1;
                if (cls == 6) begin
                    if (w >= lim) flag_error(ST_RANGE);
                    else w = w + 1;
                end else if (w > lim) flag_error(ST_RANGE);
            end else begin
                // Walk the promotion list; hex, octal and binary may use unsigned types.
                stp = (cls % 2 == 0 && lex_radix != RX_DEC) ? 1 : 2;
                while (cls <= 5 && lex_accum > type_limit(3'(cls))) cls += stp;
                if (cls > 5) flag_error(ST_RANGE);
                w = 0;
            end
        end
        if (lex_err != ST_OK) r = '{64'd0, 7'd0, 3'd0, lex_err};
        else r = '{lex_accum, 7'(w), 3'(cls), ST_OK};
        expected_results.push_back(r);
        clear_lexer();
    endfunction

    // Sends one character beat, idling first as the current mix asks.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= is_last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        lex_char(c, is_last);
    endtask

    // Valid stays up between tokens; drain() drops it when the stream pauses.
    task automatic send_token(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // Waits for all results, then for the output stage to settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_INT_BITS:  int_w = val;
            REG_LONG_BITS: long_w = val;
            default:       bitint_w = val;
        endcase
    endtask

    task automatic set_widths(input logic [6:0] iw, input logic [6:0] lw, input logic [6:0] bw);
        drain();
        write_reg(REG_INT_BITS, iw);
        write_reg(REG_LONG_BITS, lw);
        write_reg(REG_BITINT_BITS, bw);
        cfg_valid <= 1'b0;
    endtask

    // Result checker: compares each accepted beat with the oldest expectation.
    always @(posedge clk)
    begin
        lit_result_t got;
        lit_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = lit_result_t'(m_axis_tdata[75:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.type_class !== want.type_class
                    || got.bitint_bits !== want.bitint_bits || got.value !== want.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp st=%0d cl=%0d bi=%0d v=%h, got st=%0d cl=%0d bi=%0d v=%h",
                            want.status, want.type_class, want.bitint_bits, want.value,
                            got.status, got.type_class, got.bitint_bits, got.value);
                end
            end
        end
    end

    // Receiver ready: random stalls, or a long hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        string toks[$];
        toks = '{"0", "7", "123", "0x1F", "0XaBu", "0b101", "0B1'0", "0777", "08", "0x",
                 "0b", "0x'", "0xu", "1'000", "1''0", "1'", "18446744073709551615",
                 "18446744073709551616", "0xFFFFFFFFFFFFFFFF", "9223372036854775808",
                 "0xffffffffffffffffff", "42ull", "7wb", "0xFFuwb", "1ulll"};
        foreach (toks[i]) send_token(toks[i]);
        // Every listed suffix once, plus a few rejected ones and odd bytes.
        toks = '{"1L", "1LL", "1LLU", "1LLu", "1LU", "1Lu", "1U", "1UL", "1ULL", "1UWB",
                 "1Ul", "1Ull", "1Uwb", "1WB", "1WBU", "1WBu", "1l", "1lU", "1ll", "1llU",
                 "1llu", "1lu", "1u", "1uL", "1uLL", "1uWB", "1ul", "1ull", "1uwb", "1wb",
                 "1wbU", "1wbu", "1Ll", "1lL", "1wB", "x1", "-1"};
        foreach (toks[i]) send_token(toks[i]);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(8'h00, 1'b1);
    endtask

    // Width registers saturated from below and from above.
    task automatic test_widths();
        string toks[$];
        toks = '{"32768", "65536", "0x8000", "2147483648", "0xFFFFFFFF", "4294967296",
                 "1WB", "3wb", "0xFFFFFFFFFFFFFFFFuwb", "0x7FFFFFFFFFFFFFFFwb"};
        set_widths(7'd0, 7'd127, 7'd0);
        foreach (toks[i]) send_token(toks[i]);
        set_widths(7'd100, 7'd5, 7'd127);
        foreach (toks[i]) send_token(toks[i]);
    endtask

    function automatic string random_token();
        string s;
        string digs;
        string sfx[$];
        int    n;
        sfx = '{"", "", "u", "L", "ll", "ULL", "wb", "uwb", "lu", "Lu", "x", "uLl", "llll"};
        case ($urandom_range(3))
            0: begin s = "0x"; digs = "0123456789abcdefABCDEF'"; end
            1: begin s = "0b"; digs = "01'"; end
            2: begin s = "0";  digs = "01234567'"; end
            default: begin s = string'(8'("1") + 8'($urandom_range(8))); digs = "0123456789'"; end
        endcase
        n = $urandom_range(1) ? $urandom_range(4) : $urandom_range(24);
        for (int i = 0; i < n; i++) s = {s, string'(digs[$urandom_range(digs.len() - 1)])};
        s = {s, sfx[$urandom_range(sfx.size() - 1)]};
        // Occasional noise byte anywhere in the token.
        if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
        return s;
    endfunction

    task automatic test_random(input int char_goal);
        int sent;
        string s;
        sent = 0;
        while (sent < char_goal) begin
            s = random_token();
            send_token(s);
            sent += s.len();
        end
    endtask

    // Receiver holds off for a long stretch while tokens keep coming.
    task automatic test_backpressure();
        hold_off_cycles = 300;
        send_idle_pct = 0;
        test_random(30);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        int_w = 7'd32;
        long_w = 7'd64;
        bitint_w = 7'd64;
        clear_lexer();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_widths();
        set_widths(7'd32, 7'd64, 7'd64);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(20);
        send_idle_pct = 81;
        test_random(20);
        send_idle_pct = 0;
        recv_stall_pct = 81;
        test_random(20);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        set_widths(7'd32, 7'd32, 7'd40);
        test_random(20);
        test_backpressure();
        recv_stall_pct = 0;
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[c_integer_literal_parser.f]
rtl/cilp_pkg.sv
rtl/cilp_scan.sv
rtl/cilp_finish.sv
rtl/c_integer_literal_parser.sv
tb/sv/tb_top.sv
